/* rtl/lprr_pkg.sv */
// Package for the LRU page replacement block: field widths, defaults and the
// lookup result type shared by the frame set and the top level. No dependencies.
package lprr_pkg;

	localparam int PAGE_W          = 16;
	localparam int CFG_W           = 4;
	localparam int CNT_W           = 32;
	localparam int DEF_MAX_FRAMES  = 8;
	localparam int DEF_PAGE_BITS   = 16;
	localparam int RESET_FRAMES    = 8;
	localparam int OUT_FIELDS_W    = 2 + PAGE_W + 2 * CNT_W;
	localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef struct packed {
		logic              hit;
		logic              evicted_valid;
		logic [PAGE_W-1:0] evicted_page;
	} lookup_t;

endpackage

/* rtl/lprr_frame_set.sv */
// Fully associative frame set with recency ranks: tag compare, victim and free
// frame selection, rank update. Depends on lprr_pkg.
module lprr_frame_set #(
	parameter int MAX_FRAMES = lprr_pkg::DEF_MAX_FRAMES,
	parameter int PAGE_BITS  = lprr_pkg::DEF_PAGE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lprr_pkg::CFG_W-1:0]  cfg_frames,
	input  logic                        step,
	input  logic [lprr_pkg::PAGE_W-1:0] page,
	output lprr_pkg::lookup_t           lookup
);

	localparam int RW      = $clog2(MAX_FRAMES + 1);
	localparam int SW      = (PAGE_BITS < lprr_pkg::PAGE_W) ? PAGE_BITS : lprr_pkg::PAGE_W;
	localparam int RESET_N = (lprr_pkg::RESET_FRAMES > MAX_FRAMES) ?
		MAX_FRAMES : lprr_pkg::RESET_FRAMES;

	logic [SW-1:0]         page_q [MAX_FRAMES];
	logic [RW-1:0]         rank_q [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] valid_q;
	logic [RW-1:0]         n_q;
	logic [RW-1:0]         n_new;

	logic [SW-1:0]         pg;
	logic [MAX_FRAMES-1:0] in_range, match, match_oh, cand, victim_oh, free, free_oh, slot_oh;
	logic [MAX_FRAMES-1:0] rank_bad;
	logic                  free_any;
	logic [RW-1:0]         hit_rank;
	logic [SW-1:0]         victim_page;

	assign pg = page[SW-1:0];

	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			in_range[i] = i < int'(n_q);
			match[i]    = valid_q[i] && (page_q[i] == pg);
			cand[i]     = valid_q[i] && (rank_q[i] == RW'(1));
			free[i]     = !valid_q[i] && in_range[i];
			rank_bad[i] = valid_q[i] && ((rank_q[i] == '0) || (rank_q[i] > n_q));
		end
	end

	assign match_oh  = match & (~match + MAX_FRAMES'(1));
	assign victim_oh = cand & (~cand + MAX_FRAMES'(1));
	assign free_oh   = free & (~free + MAX_FRAMES'(1));
	assign free_any  = |free;
	assign slot_oh   = free_any ? free_oh : victim_oh;

	always_comb begin
		hit_rank    = '0;
		victim_page = '0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			if (match_oh[i]) begin
				hit_rank = hit_rank | rank_q[i];
			end
			if (victim_oh[i]) begin
				victim_page = victim_page | page_q[i];
			end
		end
	end

	always_comb begin
		lookup.hit           = |match;
		lookup.evicted_valid = !(|match) && !free_any;
		lookup.evicted_page  = lookup.evicted_valid ? lprr_pkg::PAGE_W'(victim_page) : '0;
	end

	always_comb begin
		if (cfg_frames == '0) begin
			n_new = RW'(1);
		end else if (int'(cfg_frames) > MAX_FRAMES) begin
			n_new = RW'(MAX_FRAMES);
		end else begin
			n_new = RW'(cfg_frames);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			n_q     <= RW'(RESET_N);
			for (int i = 0; i < MAX_FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cfg_we) begin
			valid_q <= '0;
			n_q     <= n_new;
			for (int i = 0; i < MAX_FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (step) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				if (|match) begin
					if (match_oh[i]) begin
						rank_q[i] <= n_q;
					end else if (valid_q[i] && rank_q[i] > hit_rank) begin
						rank_q[i] <= rank_q[i] - RW'(1);
					end
				end else if (slot_oh[i]) begin
					rank_q[i]  <= n_q;
					valid_q[i] <= 1'b1;
				end else if (valid_q[i] && rank_q[i] != '0) begin
					rank_q[i] <= rank_q[i] - RW'(1);
				end
			end
		end
	end

	// page tags, only read while the frame is valid
	always_ff @(posedge clk) begin
		if (step && !cfg_we && !(|match)) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				if (slot_oh[i]) begin
					page_q[i] <= pg;
				end
			end
		end
	end

	a_valid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q & ~in_range) == '0)
		else $error("valid frame beyond active frame count");

	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		rank_bad == '0)
		else $error("valid frame rank outside 1..n");

	a_one_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !cfg_we && !(|match) && !free_any) |-> $onehot(victim_oh))
		else $error("full miss without a unique LRU frame");

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !cfg_we && !(|match) && free_any) |=>
		($countones(valid_q) == $past($countones(valid_q)) + 1))
		else $error("miss with free frame did not fill one frame");

endmodule

/* rtl/lprr_stats.sv */
// Saturating reference and fault counters; exposes the post-update totals.
// Depends on lprr_pkg.
module lprr_stats (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       fault,
	output logic [lprr_pkg::CNT_W-1:0] reference_next,
	output logic [lprr_pkg::CNT_W-1:0] fault_next
);

	logic [lprr_pkg::CNT_W-1:0] reference_q;
	logic [lprr_pkg::CNT_W-1:0] fault_q;

	assign reference_next = (reference_q == '1) ? reference_q :
		reference_q + lprr_pkg::CNT_W'(1);
	assign fault_next     = (fault && fault_q != '1) ? fault_q + lprr_pkg::CNT_W'(1) :
		fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_q <= '0;
			fault_q     <= '0;
		end else if (step) begin
			reference_q <= reference_next;
			fault_q     <= fault_next;
		end
	end

endmodule

/* rtl/lru_page_replacement_ranks.sv */
// Top level of the LRU page replacement block: input register, frame set,
// counters and result register. Depends on lprr_pkg, lprr_frame_set, lprr_stats.
//
// Each page reference on s_tdata is taken into the input register and yields
// one result on m_tdata from the result register; a new reference can be
// taken every cycle while m_tready does not stall the output, as the tag
// compare over all frames is combinational and the next reference sees the
// frames with their ranks updated. The result register holds a finished item
// while the next one is taken, and both sides stall cleanly. A write on the
// cfg channel sets the active frame count (0 acts as 1, values above
// MAX_FRAMES act as MAX_FRAMES) and empties all frames; the counters keep
// their values. Write it only while no item is in flight.
module lru_page_replacement_ranks #(
	parameter int MAX_FRAMES = lprr_pkg::DEF_MAX_FRAMES,
	parameter int PAGE_BITS  = lprr_pkg::DEF_PAGE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lprr_pkg::PAGE_W-1:0]      s_tdata,   // page_number
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// hit, evicted_valid, evicted_page, reference_total, fault_total, zero pad
	output logic [lprr_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lprr_pkg::CFG_W-1:0]       cfg_data   // frames_in_use
);

	logic                             valid_s1;
	logic [lprr_pkg::PAGE_W-1:0]      page_s1;
	logic                             out_valid_q;
	logic [lprr_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic                             advance;
	logic                             cfg_we;
	lprr_pkg::lookup_t                lookup;
	logic [lprr_pkg::CNT_W-1:0]       reference_next;
	logic [lprr_pkg::CNT_W-1:0]       fault_next;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	lprr_frame_set #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS)
	) u_frames (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_frames (cfg_data),
		.step       (advance),
		.page       (page_s1),
		.lookup     (lookup)
	);

	lprr_stats u_stats (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.fault          (!lookup.hit),
		.reference_next (reference_next),
		.fault_next     (fault_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			page_s1 <= s_tdata;
		end
		if (advance) begin
			out_data_q <= lprr_pkg::OUT_TDATA_W'({fault_next, reference_next,
				lookup.evicted_page, lookup.evicted_valid, lookup.hit});
		end
	end

endmodule
